// ===== design/gsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot allocator package
// Field widths and action codes shared by the allocator and its users.
// ----------------------------------------------------------------------------
package gsa_pkg;

    localparam int ACTION_W = 2;
    localparam int HANDLE_W = 32;
    localparam int NUM_W    = 6;
    localparam int OFFSET_W = 38;
    localparam int COUNT_W  = 7;
    localparam int CFG_W    = 32;

    typedef logic [ACTION_W-1:0] action_t;

    localparam action_t ACT_ALLOC   = 2'd0;
    localparam action_t ACT_RELEASE = 2'd1;
    localparam action_t ACT_CHECK   = 2'd2;
    localparam action_t ACT_NOP     = 2'd3;

endpackage

// ===== design/generational_slot_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot allocator
// Pool of fixed slots handed out as handles of an index and a generation.
// ----------------------------------------------------------------------------
// Usage: one request word enters on the s_ channel (action, handle index,
// handle generation) and exactly one result word leaves on the m_ channel.
// Allocate pops the free stack, release retires a valid handle and bumps the
// slot generation (skipping zero), check validates a handle and returns the
// byte offset index * slot_bytes. The cfg_ channel writes slot_bytes; it is
// always ready and is meant to be written while no request is in flight.
// A release, check or no-op word passes from acceptance through the finish
// state into the output register; the next word is accepted once the state
// machine is back in idle. An allocate passes the lookup state first, as the
// generation lookup can only start once the free-stack read has returned the
// slot. The pacing is set by the single read port of the generation memory,
// which is read, then written back when the result is produced.
// After reset the free stack and generation table behave as freshly cleared
// without a clearing pass: a low-water mark of the stack depth tells which
// stack entries and which slots have ever been written.
// When the receiver stalls, the finished word waits in the output register;
// one further request is taken and held at its write-back until the output
// register frees, so no state changes before its result can be delivered.
// ----------------------------------------------------------------------------
module generational_slot_allocator_unit #(
    parameter int SLOTS    = 64,
    parameter int GEN_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gsa_pkg::CFG_W-1:0]         cfg_wdata,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  gsa_pkg::action_t                  s_action,
    input  logic [gsa_pkg::HANDLE_W-1:0]      s_handle_index,
    input  logic [gsa_pkg::HANDLE_W-1:0]      s_handle_generation,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_success,
    output logic [gsa_pkg::NUM_W-1:0]         m_slot_number,
    output logic [gsa_pkg::HANDLE_W-1:0]      m_slot_generation,
    output logic [gsa_pkg::OFFSET_W-1:0]      m_slot_offset,
    output logic [gsa_pkg::COUNT_W-1:0]       m_free_slots_left,
    output logic [gsa_pkg::COUNT_W-1:0]       m_slots_occupied
);

    import gsa_pkg::*;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int PROD_W = IDX_W + CFG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_FINISH
    } state_t;

    // Control state.
    state_t                state_reg;
    logic [CNT_W-1:0]      free_depth_reg;
    logic [CNT_W-1:0]      occ_total_reg;
    // Lowest stack depth ever reached: stack positions below it were never
    // written, and slots numbered SLOTS - min_depth or above were never used.
    logic [CNT_W-1:0]      min_depth_reg;
    logic                  out_valid_reg;
    logic [CFG_W-1:0]      slot_bytes_reg;

    // Request held while it is worked on.
    action_t               act_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [HANDLE_W-1:0]   hgen_reg;
    logic                  in_range_reg;
    logic                  pop_fresh_reg;

    // Result register.
    logic                  out_success_reg;
    logic [NUM_W-1:0]      out_number_reg;
    logic [HANDLE_W-1:0]   out_gen_reg;
    logic [OFFSET_W-1:0]   out_offset_reg;
    logic [COUNT_W-1:0]    out_free_reg;
    logic [COUNT_W-1:0]    out_occ_reg;

    // Memories: generation table entries carry the occupied flag on top.
    logic [GEN_BITS:0]     gen_mem [SLOTS];
    logic [GEN_BITS:0]     gen_rdata_reg;
    logic [IDX_W-1:0]      stack_mem [SLOTS];
    logic [IDX_W-1:0]      stk_rdata_reg;

    // Combinational signals.
    logic                  accept;
    logic                  fin_go;
    logic [IDX_W-1:0]      pop_pos;
    logic [IDX_W-1:0]      popped_slot;
    logic                  gen_re;
    logic [IDX_W-1:0]      gen_raddr;
    logic                  gen_we;
    logic [GEN_BITS:0]     gen_wdata;
    logic                  stk_we;
    logic                  entry_valid;
    logic                  cur_occ;
    logic [GEN_BITS-1:0]   cur_gen;
    logic [GEN_BITS-1:0]   bumped_gen;
    logic                  handle_hit;
    logic [PROD_W-1:0]     product;
    logic                  res_success;
    logic [HANDLE_W-1:0]   res_gen;
    logic [OFFSET_W-1:0]   res_offset;
    logic [CNT_W-1:0]      free_depth_next;
    logic [CNT_W-1:0]      occ_total_next;
    logic [CNT_W-1:0]      min_depth_next;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign fin_go    = (state_reg == S_FINISH) && (!out_valid_reg || m_ready);

    // The top of the stack sits at depth - 1; a position under the low-water
    // mark still holds its reset contents, slot SLOTS - 1 - position.
    assign pop_pos     = IDX_W'(free_depth_reg - 1'b1);
    assign popped_slot = pop_fresh_reg ? (IDX_W'(SLOTS - 1) - pop_pos) : stk_rdata_reg;

    // One read port on the generation table: the handle index on accept, the
    // popped slot in the lookup step of an allocate.
    assign gen_re    = accept || (state_reg == S_LOOKUP);
    assign gen_raddr = (state_reg == S_LOOKUP) ? popped_slot : IDX_W'(s_handle_index);

    always_comb begin
        entry_valid = (SUM_W'(slot_reg) + SUM_W'(min_depth_reg)) < SUM_W'(SLOTS);
        cur_occ     = entry_valid && gen_rdata_reg[GEN_BITS];
        cur_gen     = entry_valid ? gen_rdata_reg[GEN_BITS-1:0] : '0;
        bumped_gen  = cur_gen + 1'b1;
        if (bumped_gen == '0) begin
            bumped_gen = GEN_BITS'(1);
        end
        handle_hit  = in_range_reg && cur_occ && (HANDLE_W'(cur_gen) == hgen_reg);
        product     = PROD_W'(slot_reg) * PROD_W'(slot_bytes_reg);

        res_success     = 1'b0;
        res_gen         = '0;
        res_offset      = '0;
        gen_we          = 1'b0;
        gen_wdata       = {1'b1, cur_gen};
        stk_we          = 1'b0;
        free_depth_next = free_depth_reg;
        occ_total_next  = occ_total_reg;
        min_depth_next  = min_depth_reg;

        case (act_reg)
            ACT_ALLOC: begin
                if (free_depth_reg != '0) begin
                    res_success     = 1'b1;
                    res_gen         = HANDLE_W'(cur_gen);
                    gen_we          = fin_go;
                    gen_wdata       = {1'b1, cur_gen};
                    free_depth_next = free_depth_reg - 1'b1;
                    occ_total_next  = occ_total_reg + 1'b1;
                    if (free_depth_next < min_depth_reg) begin
                        min_depth_next = free_depth_next;
                    end
                end
            end
            ACT_RELEASE: begin
                if (handle_hit) begin
                    res_success = 1'b1;
                    res_gen     = HANDLE_W'(bumped_gen);
                    gen_we      = fin_go;
                    gen_wdata   = {1'b0, bumped_gen};
                    if (free_depth_reg < CNT_W'(SLOTS)) begin
                        stk_we          = fin_go;
                        free_depth_next = free_depth_reg + 1'b1;
                    end
                    if (occ_total_reg != '0) begin
                        occ_total_next = occ_total_reg - 1'b1;
                    end
                end
            end
            ACT_CHECK: begin
                if (handle_hit) begin
                    res_success = 1'b1;
                    res_gen     = HANDLE_W'(cur_gen);
                    res_offset  = OFFSET_W'(product);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (gen_we) begin
            gen_mem[slot_reg] <= gen_wdata;
        end
        if (gen_re) begin
            gen_rdata_reg <= gen_mem[gen_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[IDX_W'(free_depth_reg)] <= slot_reg;
        end
        if (accept) begin
            stk_rdata_reg <= stack_mem[pop_pos];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            free_depth_reg <= CNT_W'(SLOTS);
            occ_total_reg  <= '0;
            min_depth_reg  <= CNT_W'(SLOTS);
            out_valid_reg  <= 1'b0;
            slot_bytes_reg <= '0;
        end else begin
            if (cfg_valid) begin
                slot_bytes_reg <= cfg_wdata;
            end
            // A finishing request refills the output register in the same
            // cycle that the receiver takes the previous word.
            if (fin_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        act_reg       <= s_action;
                        slot_reg      <= IDX_W'(s_handle_index);
                        hgen_reg      <= s_handle_generation;
                        in_range_reg  <= s_handle_index < HANDLE_W'(SLOTS);
                        pop_fresh_reg <= free_depth_reg <= min_depth_reg;
                        state_reg     <= (s_action == ACT_ALLOC) ? S_LOOKUP : S_FINISH;
                    end
                end
                S_LOOKUP: begin
                    slot_reg  <= popped_slot;
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (fin_go) begin
                        free_depth_reg  <= free_depth_next;
                        occ_total_reg   <= occ_total_next;
                        min_depth_reg   <= min_depth_next;
                        out_success_reg <= res_success;
                        out_number_reg  <= res_success ? NUM_W'(slot_reg) : '0;
                        out_gen_reg     <= res_gen;
                        out_offset_reg  <= res_offset;
                        out_free_reg    <= COUNT_W'(free_depth_next);
                        out_occ_reg     <= COUNT_W'(occ_total_next);
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_success         = out_success_reg;
    assign m_slot_number     = out_number_reg;
    assign m_slot_generation = out_gen_reg;
    assign m_slot_offset     = out_offset_reg;
    assign m_free_slots_left = out_free_reg;
    assign m_slots_occupied  = out_occ_reg;

    // Every slot is either on the free stack or occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (SUM_W'(free_depth_reg) + SUM_W'(occ_total_reg)) == SUM_W'(SLOTS))
        else $error("free depth and occupied count do not add up to the pool size");

    // The low-water mark never lies above the current depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        min_depth_reg <= free_depth_reg)
        else $error("stack low-water mark above current depth");

    // A finished request always shows up as a pending result word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fin_go |=> out_valid_reg)
        else $error("result word lost after write-back");

    // A release never writes generation zero back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (gen_we && (act_reg == ACT_RELEASE)) |-> (gen_wdata[GEN_BITS-1:0] != '0))
        else $error("released slot got generation zero");

endmodule

// ===== verif/tb_generational_slot_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot allocator testbench
// Drives request words into the allocator and checks every result word
// against a cycle-free model of the slot pool that runs beside it. It holds
// the free stack, occupancy, generations and slot size. A short directed
// pass walks two handles through their whole life. Three randomized phases
// then drain the pool to empty, mix traffic and refill it, the sender and
// receiver idling in turn, then neither. Each phase has its own slot size.
// ----------------------------------------------------------------------------
module tb_generational_slot_allocator_unit;

    import gsa_pkg::*;

    localparam int SLOTS          = 64;
    localparam int GEN_BITS       = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 10;

    localparam logic [HANDLE_W-1:0] GEN_MASK = HANDLE_W'((64'd1 << GEN_BITS) - 64'd1);

    // One result word as the allocator presents it on the m_ channel.
    typedef struct packed {
        logic                success;
        logic [NUM_W-1:0]    slot_number;
        logic [HANDLE_W-1:0] slot_generation;
        logic [OFFSET_W-1:0] slot_offset;
        logic [COUNT_W-1:0]  free_slots_left;
        logic [COUNT_W-1:0]  slots_occupied;
    } alloc_result_t;

    // Every input starts at a known value; the reset is held from time zero.
    logic                aclk                = 1'b0;
    logic                aresetn             = 1'b0;
    logic                cfg_valid           = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_wdata           = '0;
    logic                s_valid             = 1'b0;
    logic                s_ready;
    action_t             s_action            = ACT_NOP;
    logic [HANDLE_W-1:0] s_handle_index      = '0;
    logic [HANDLE_W-1:0] s_handle_generation = '0;
    logic                m_valid;
    logic                m_ready             = 1'b0;
    logic                m_success;
    logic [NUM_W-1:0]    m_slot_number;
    logic [HANDLE_W-1:0] m_slot_generation;
    logic [OFFSET_W-1:0] m_slot_offset;
    logic [COUNT_W-1:0]  m_free_slots_left;
    logic [COUNT_W-1:0]  m_slots_occupied;

    // Model of the slot pool. It advances once for every request word that
    // the allocator accepts, so its state always matches the accepted stream.
    logic [NUM_W-1:0]    free_stack_model [SLOTS];
    logic                occupied_model   [SLOTS];
    logic [HANDLE_W-1:0] gen_model        [SLOTS];
    int                  free_depth_model;
    int                  occupied_count_model;
    logic [CFG_W-1:0]    slot_bytes_model;

    // Result words still owed by the allocator, oldest first.
    alloc_result_t       pending_results [$];

    int                  mismatch_count = 0;
    int                  send_idle_pct  = 0;
    int                  recv_idle_pct  = 0;
    int                  stall_cycles   = 0;

    always #1 aclk = ~aclk;

    generational_slot_allocator_unit #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    ) i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_handle_index      (s_handle_index),
        .s_handle_generation (s_handle_generation),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_success           (m_success),
        .m_slot_number       (m_slot_number),
        .m_slot_generation   (m_slot_generation),
        .m_slot_offset       (m_slot_offset),
        .m_free_slots_left   (m_free_slots_left),
        .m_slots_occupied    (m_slots_occupied)
    );

    // ------------------------------------------------------------------------
    // Pool model
    // ------------------------------------------------------------------------

    // After reset the stack top holds slot 0, so allocations count upward.
    task automatic reset_pool_model();
        for (int i = 0; i < SLOTS; i++) begin
            free_stack_model[i] = NUM_W'(SLOTS - 1 - i);
            occupied_model[i]   = 1'b0;
            gen_model[i]        = '0;
        end
        free_depth_model     = SLOTS;
        occupied_count_model = 0;
        slot_bytes_model     = '0;
    endtask

    // A handle is live when its index is in range, the slot is taken and
    // the generation matches exactly.
    function automatic logic handle_is_live(logic [HANDLE_W-1:0] idx,
                                            logic [HANDLE_W-1:0] gen);
        if (idx >= SLOTS)
            return 1'b0;
        return occupied_model[idx[NUM_W-1:0]] && (gen_model[idx[NUM_W-1:0]] == gen);
    endfunction

    // Applies one accepted request to the model and returns the result word
    // that the allocator must produce for it.
    function automatic alloc_result_t apply_pool_action(action_t act,
                                                        logic [HANDLE_W-1:0] idx,
                                                        logic [HANDLE_W-1:0] gen);
        alloc_result_t       res;
        logic [NUM_W-1:0]    slot;
        logic [HANDLE_W-1:0] next_gen;
        logic [63:0]         product;
        res = '0;
        case (act)
            ACT_ALLOC: begin
                // An empty stack fails and leaves the pool as it was.
                if (free_depth_model > 0) begin
                    free_depth_model--;
                    slot = free_stack_model[free_depth_model];
                    occupied_model[slot] = 1'b1;
                    occupied_count_model++;
                    res.success         = 1'b1;
                    res.slot_number     = slot;
                    res.slot_generation = gen_model[slot];
                end
            end
            ACT_RELEASE: begin
                if (handle_is_live(idx, gen)) begin
                    slot     = idx[NUM_W-1:0];
                    // The generation wraps past zero straight to one.
                    next_gen = (gen_model[slot] + 1'b1) & GEN_MASK;
                    if (next_gen == '0)
                        next_gen = 1;
                    gen_model[slot]      = next_gen;
                    occupied_model[slot] = 1'b0;
                    if (free_depth_model < SLOTS) begin
                        free_stack_model[free_depth_model] = slot;
                        free_depth_model++;
                    end
                    if (occupied_count_model > 0)
                        occupied_count_model--;
                    res.success         = 1'b1;
                    res.slot_number     = slot;
                    res.slot_generation = next_gen;
                end
            end
            ACT_CHECK: begin
                if (handle_is_live(idx, gen)) begin
                    slot    = idx[NUM_W-1:0];
                    product = 64'(idx) * 64'(slot_bytes_model);
                    res.success         = 1'b1;
                    res.slot_number     = slot;
                    res.slot_generation = gen_model[slot];
                    res.slot_offset     = product[OFFSET_W-1:0];
                end
            end
            default: begin
                // The no-op action only reports the counts.
            end
        endcase
        res.free_slots_left = COUNT_W'(free_depth_model);
        res.slots_occupied  = COUNT_W'(occupied_count_model);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Drops valid and waits until every owed result word has been delivered.
    task automatic wait_pool_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Presents one request word and keeps it steady until it is accepted.
    // Valid is left high on return so that back-to-back words stream without
    // a gap; the idle cycles, when drawn, come before the next word.
    task automatic send_request(input action_t act, input logic [HANDLE_W-1:0] idx,
                                input logic [HANDLE_W-1:0] gen, input bit hold_off);
        if (hold_off)
            wait_pool_idle();
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_action            <= act;
        s_handle_index      <= idx;
        s_handle_generation <= gen;
        do
            @(posedge aclk);
        while (!s_ready);
        pending_results.push_back(apply_pool_action(act, idx, gen));
    endtask

    // The slot size changes only while the pool has nothing in flight.
    task automatic write_slot_bytes(input logic [CFG_W-1:0] value);
        wait_pool_idle();
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        slot_bytes_model = value;
        cfg_valid <= 1'b0;
    endtask

    // Draws a slot, looking for one whose occupancy is as asked for; after a
    // few misses the last draw is taken as it is.
    function automatic int pick_slot(bit want_occupied);
        int slot;
        slot = $urandom_range(SLOTS - 1);
        for (int tries = 0; tries < 8 && occupied_model[slot] != want_occupied; tries++)
            slot = $urandom_range(SLOTS - 1);
        return slot;
    endfunction

    // One randomized request word. Most words carry well-formed handles taken
    // from the model so that releases and checks mostly hit live slots; the
    // rest are stale generations, indexes past the pool and raw noise.
    task automatic issue_random_request(input int alloc_weight);
        int                  pick;
        int                  kind;
        int                  slot;
        action_t             act;
        logic [HANDLE_W-1:0] idx;
        logic [HANDLE_W-1:0] gen;
        pick = $urandom_range(99);
        act  = ACT_ALLOC;
        idx  = $urandom;
        gen  = $urandom;
        if (pick >= alloc_weight) begin
            kind = (pick - alloc_weight) * 10 / (100 - alloc_weight);
            slot = pick_slot(kind < 7 || $urandom_range(1) == 0);
            idx  = slot;
            gen  = gen_model[slot];
            case (kind)
                0, 1, 2, 3: act = ACT_RELEASE;
                4, 5, 6:    act = ACT_CHECK;
                7: begin
                    // A generation one behind is the handle of a past life, one ahead a future one.
                    act = $urandom_range(1) ? ACT_RELEASE : ACT_CHECK;
                    gen = gen + ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
                end
                8: begin
                    act = $urandom_range(1) ? ACT_RELEASE : ACT_CHECK;
                    idx = $urandom_range(32'hFFFF_FFFF, SLOTS);
                end
                default: begin
                    act = action_t'($urandom_range(3));
                    idx = $urandom;
                    gen = $urandom;
                end
            endcase
        end
        send_request(act, idx, gen, $urandom_range(39) == 0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Walks two handles through allocate, check, release and reuse. Along
    // the way it presents unoccupied, stale, mismatched and out-of-range
    // handles and the no-op action with all field bits at both extremes.
    task automatic test_handle_lifecycle();
        send_request(ACT_CHECK,   32'd0,         32'd0,         1'b0);
        send_request(ACT_RELEASE, 32'd0,         32'd0,         1'b0);
        send_request(ACT_ALLOC,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_request(ACT_CHECK,   32'd0,         32'd0,         1'b0);
        send_request(ACT_ALLOC,   32'd0,         32'd0,         1'b0);
        send_request(ACT_CHECK,   32'd1,         32'd0,         1'b0);
        send_request(ACT_CHECK,   32'd1,         32'hFFFF_FFFF, 1'b0);
        send_request(ACT_CHECK,   SLOTS,         32'd0,         1'b0);
        send_request(ACT_CHECK,   32'hFFFF_FFFF, 32'd0,         1'b0);
        send_request(ACT_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_request(ACT_RELEASE, 32'd1,         32'd0,         1'b0);
        // The same handle again is stale now.
        send_request(ACT_RELEASE, 32'd1,         32'd0,         1'b0);
        send_request(ACT_CHECK,   32'd1,         32'd1,         1'b0);
        // The released slot is back on top of the stack with generation one.
        send_request(ACT_ALLOC,   32'd0,         32'd0,         1'b0);
        send_request(ACT_CHECK,   32'd1,         32'd1,         1'b0);
        send_request(ACT_NOP,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_request(ACT_NOP,     32'd0,         32'd0,         1'b0);
        send_request(ACT_RELEASE, 32'd0,         32'd0,         1'b0);
        send_request(ACT_RELEASE, 32'd1,         32'd1,         1'b0);
        send_request(ACT_CHECK,   32'd0,         32'd1,         1'b0);
    endtask

    // Allocation-heavy traffic that runs the free stack dry and keeps
    // allocating on the empty stack for a while.
    task automatic test_pool_exhaustion();
        repeat (100) issue_random_request(85);
    endtask

    // Balanced traffic around a mostly full pool.
    task automatic test_mixed_traffic();
        repeat (100) issue_random_request(30);
    endtask

    // Release-heavy traffic that hands slots back until the stack refills.
    task automatic test_pool_refill();
        repeat (80) issue_random_request(5);
    endtask

    task automatic run_traffic_phase(input int sender_pct, input int receiver_pct,
                                     input logic [CFG_W-1:0] bytes);
        write_slot_bytes(bytes);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        test_pool_exhaustion();
        test_mixed_traffic();
        test_pool_refill();
    endtask

    // ------------------------------------------------------------------------
    // Result side, checking and watchdog
    // ------------------------------------------------------------------------

    // Everything here samples the values that stood before the clock edge,
    // since all stimulus changes through nonblocking assignments at the edge.
    always @(posedge aclk) begin
        alloc_result_t seen;
        alloc_result_t want;
        if (!aresetn) begin
            m_ready      <= 1'b0;
            stall_cycles <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                seen = '{m_success, m_slot_number, m_slot_generation, m_slot_offset,
                         m_free_slots_left, m_slots_occupied};
                if (pending_results.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: result word with nothing owed: %p", $realtime, seen);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (seen.success !== want.success
                        || seen.slot_number !== want.slot_number
                        || seen.slot_generation !== want.slot_generation
                        || seen.slot_offset !== want.slot_offset
                        || seen.free_slots_left !== want.free_slots_left
                        || seen.slots_occupied !== want.slots_occupied) begin
                        if (mismatch_count < MAX_REPORTS) begin
                            $display("%0t: result word mismatch", $realtime);
                            $display("  expected %p", want);
                            $display("  actual   %p", seen);
                        end
                        mismatch_count++;
                    end
                end
            end
            // Any word moved on any channel proves the allocator is alive.
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin
        reset_pool_model();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // The largest slot size first, so that even a slot-one check already
        // carries a product that fills the low 32 offset bits.
        write_slot_bytes(32'hFFFF_FFFF);
        test_handle_lifecycle();

        // Sender mostly busy and receiver mostly stalled, then the reverse,
        // then both sides at full rate with the largest slot size again.
        run_traffic_phase(6, 77, $urandom);
        run_traffic_phase(77, 6, 32'h0000_0000);
        run_traffic_phase(0, 0, 32'hFFFF_FFFF);

        wait_pool_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
